// File: rtl/ebalu_pkg.sv
// types and constants shared by the alu pipeline stages
// no dependencies; compile first

package ebalu_pkg;

   localparam logic [7:0] DAA_LIMIT = 8'h99;
   localparam logic [7:0] DAA_HIGH  = 8'h60;
   localparam logic [7:0] DAA_LOW   = 8'h06;
   localparam logic [3:0] BCD_MAX   = 4'h9;

   typedef enum logic [5:0] {
      FN_ADD8   = 6'd0,
      FN_ADC    = 6'd1,
      FN_SUB    = 6'd2,
      FN_SBC    = 6'd3,
      FN_AND    = 6'd4,
      FN_XOR    = 6'd5,
      FN_OR     = 6'd6,
      FN_CP     = 6'd7,
      FN_INC8   = 6'd8,
      FN_DEC8   = 6'd9,
      FN_INC16  = 6'd10,
      FN_DEC16  = 6'd11,
      FN_ADD16  = 6'd12,
      FN_ADDSP  = 6'd13,
      FN_RLCA   = 6'd14,
      FN_RRCA   = 6'd15,
      FN_RLA    = 6'd16,
      FN_RRA    = 6'd17,
      FN_DAA    = 6'd18,
      FN_CPL    = 6'd19,
      FN_SCF    = 6'd20,
      FN_CCF    = 6'd21,
      FN_RLC    = 6'd22,
      FN_RRC    = 6'd23,
      FN_RL     = 6'd24,
      FN_RR     = 6'd25,
      FN_SLA    = 6'd26,
      FN_SRA    = 6'd27,
      FN_SWAP   = 6'd28,
      FN_SRL    = 6'd29,
      FN_BIT    = 6'd30,
      FN_RES    = 6'd31,
      FN_SET    = 6'd32
   } func_type;

   typedef struct packed {
      logic        zero;
      logic        subtract;
      logic        half_carry;
      logic        carry;
   } flags_type;

   // request as taken from the input channel
   typedef struct packed {
      func_type    func;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      flags_type   flags;
   } req_type;

   // decoded operands, handed from decode to execute
   typedef struct packed {
      func_type    func;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [15:0] offset;     // sign-extended low byte of operand_b
      logic        carry_sel;  // carry into adc and sbc
      logic [7:0]  bit_mask;
      logic [7:0]  daa_adj;
      logic        daa_carry;
      flags_type   flags;
   } dec_type;

   // raw result, handed from execute to flag merge
   typedef struct packed {
      logic [15:0] result;
      logic [7:0]  zero_src;   // byte that the zero flag is taken from
      logic        zero_test;  // zero flag comes from zero_src
      flags_type   flags;
   } exe_type;

   typedef struct packed {
      logic [15:0] result;
      flags_type   flags;
   } rsp_type;

endpackage

// File: rtl/ebalu_if.sv
// request and response channel interfaces of the alu
// depends on nothing; field names match the top level payload

interface ebalu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  func;
   logic [15:0] operand_a;
   logic [15:0] operand_b;
   logic [2:0]  bit_index;
   logic        zero_in;
   logic        subtract_in;
   logic        half_carry_in;
   logic        carry_in;

   modport source (
      output valid, func, operand_a, operand_b, bit_index,
             zero_in, subtract_in, half_carry_in, carry_in,
      input  ready
   );
   modport sink (
      input  valid, func, operand_a, operand_b, bit_index,
             zero_in, subtract_in, half_carry_in, carry_in,
      output ready
   );
endinterface

interface ebalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result;
   logic        zero_out;
   logic        subtract_out;
   logic        half_carry_out;
   logic        carry_out;

   modport source (
      output valid, result, zero_out, subtract_out, half_carry_out, carry_out,
      input  ready
   );
   modport sink (
      input  valid, result, zero_out, subtract_out, half_carry_out, carry_out,
      output ready
   );
endinterface

// File: rtl/ebalu_decode.sv
// first pipeline stage: operand preparation, bit mask and daa correction
// depends on ebalu_pkg

module ebalu_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ebalu_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ebalu_pkg::dec_type out_data
);

   logic               valid_ff;
   ebalu_pkg::dec_type data_ff;
   ebalu_pkg::dec_type data_in;
   logic [7:0]         a8;
   logic               low_adj;
   logic               high_adj;

   assign a8 = in_data.operand_a[7:0];

   // daa correction from the incoming n, h, c flags
   assign low_adj  = in_data.flags.half_carry ||
                     (!in_data.flags.subtract && (a8[3:0] > ebalu_pkg::BCD_MAX));
   assign high_adj = in_data.flags.carry ||
                     (!in_data.flags.subtract && (a8 > ebalu_pkg::DAA_LIMIT));

   always_comb begin
      data_in.func      = in_data.func;
      data_in.operand_a = in_data.operand_a;
      data_in.operand_b = in_data.operand_b;
      data_in.offset    = {{8{in_data.operand_b[7]}}, in_data.operand_b[7:0]};
      data_in.carry_sel = ((in_data.func == ebalu_pkg::FN_ADC) ||
                           (in_data.func == ebalu_pkg::FN_SBC)) && in_data.flags.carry;
      data_in.bit_mask  = 8'h01 << in_data.bit_index;
      data_in.daa_adj   = (low_adj ? ebalu_pkg::DAA_LOW : 8'h00) |
                          (high_adj ? ebalu_pkg::DAA_HIGH : 8'h00);
      data_in.daa_carry = high_adj;
      data_in.flags     = in_data.flags;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/ebalu_exec.sv
// second pipeline stage: adders, logic ops, rotates and shifts
// depends on ebalu_pkg

module ebalu_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ebalu_pkg::dec_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ebalu_pkg::exe_type out_data
);

   logic               valid_ff;
   ebalu_pkg::exe_type data_ff;
   ebalu_pkg::exe_type data_in;
   logic [7:0]         a;
   logic [7:0]         b;
   logic [8:0]         sum8;
   logic [4:0]         sum4;
   logic [8:0]         diff8;
   logic [4:0]         diff4;
   logic [16:0]        sum16;
   logic [12:0]        sum12;
   logic               cin;
   logic               cf;

   assign a   = in_data.operand_a[7:0];
   assign b   = in_data.operand_b[7:0];
   assign cin = in_data.carry_sel;
   assign cf  = in_data.flags.carry;

   assign sum8  = {1'b0, a} + {1'b0, b} + {8'b0, cin};
   assign sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
   assign diff8 = {1'b0, a} - {1'b0, b} - {8'b0, cin};
   assign diff4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};
   assign sum16 = {1'b0, in_data.operand_a} + {1'b0, in_data.operand_b};
   assign sum12 = {1'b0, in_data.operand_a[11:0]} + {1'b0, in_data.operand_b[11:0]};

   always_comb begin
      data_in.result    = in_data.operand_a;
      data_in.zero_src  = 8'h00;
      data_in.zero_test = 1'b0;
      data_in.flags     = in_data.flags;
      unique case (in_data.func)
         ebalu_pkg::FN_ADD8, ebalu_pkg::FN_ADC: begin
            data_in.result    = {8'h00, sum8[7:0]};
            data_in.zero_src  = sum8[7:0];
            data_in.zero_test = 1'b1;
            data_in.flags     = '{1'b0, 1'b0, sum4[4], sum8[8]};
         end
         ebalu_pkg::FN_SUB, ebalu_pkg::FN_SBC, ebalu_pkg::FN_CP: begin
            // cp keeps the accumulator but flags come from the difference
            if (in_data.func != ebalu_pkg::FN_CP) begin
               data_in.result = {8'h00, diff8[7:0]};
            end
            data_in.zero_src  = diff8[7:0];
            data_in.zero_test = 1'b1;
            data_in.flags     = '{1'b0, 1'b1, diff4[4], diff8[8]};
         end
         ebalu_pkg::FN_AND: begin
            data_in.result    = {8'h00, a & b};
            data_in.zero_src  = a & b;
            data_in.zero_test = 1'b1;
            data_in.flags     = '{1'b0, 1'b0, 1'b1, 1'b0};
         end
         ebalu_pkg::FN_XOR: begin
            data_in.result    = {8'h00, a ^ b};
            data_in.zero_src  = a ^ b;
            data_in.zero_test = 1'b1;
            data_in.flags     = '{1'b0, 1'b0, 1'b0, 1'b0};
         end
         ebalu_pkg::FN_OR: begin
            data_in.result    = {8'h00, a | b};
            data_in.zero_src  = a | b;
            data_in.zero_test = 1'b1;
            data_in.flags     = '{1'b0, 1'b0, 1'b0, 1'b0};
         end
         ebalu_pkg::FN_INC8: begin
            data_in.result    = {8'h00, a + 8'd1};
            data_in.zero_src  = a + 8'd1;
            data_in.zero_test = 1'b1;
            data_in.flags.subtract   = 1'b0;
            data_in.flags.half_carry = (a[3:0] == 4'hF);
         end
         ebalu_pkg::FN_DEC8: begin
            data_in.result    = {8'h00, a - 8'd1};
            data_in.zero_src  = a - 8'd1;
            data_in.zero_test = 1'b1;
            data_in.flags.subtract   = 1'b1;
            data_in.flags.half_carry = (a[3:0] == 4'h0);
         end
         ebalu_pkg::FN_INC16: begin
            data_in.result = in_data.operand_a + 16'd1;
         end
         ebalu_pkg::FN_DEC16: begin
            data_in.result = in_data.operand_a - 16'd1;
         end
         ebalu_pkg::FN_ADD16: begin
            data_in.result           = sum16[15:0];
            data_in.flags.subtract   = 1'b0;
            data_in.flags.half_carry = sum12[12];
            data_in.flags.carry      = sum16[16];
         end
         ebalu_pkg::FN_ADDSP: begin
            // flags from the unsigned low-byte sum
            data_in.result = in_data.operand_a + in_data.offset;
            data_in.flags  = '{1'b0, 1'b0, sum4[4], sum8[8]};
         end
         ebalu_pkg::FN_RLCA: begin
            data_in.result = {8'h00, a[6:0], a[7]};
            data_in.flags  = '{1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::FN_RRCA: begin
            data_in.result = {8'h00, a[0], a[7:1]};
            data_in.flags  = '{1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::FN_RLA: begin
            data_in.result = {8'h00, a[6:0], cf};
            data_in.flags  = '{1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::FN_RRA: begin
            data_in.result = {8'h00, cf, a[7:1]};
            data_in.flags  = '{1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::FN_DAA: begin
            if (in_data.flags.subtract) begin
               data_in.zero_src = a - in_data.daa_adj;
            end else begin
               data_in.zero_src = a + in_data.daa_adj;
            end
            data_in.result           = {8'h00, data_in.zero_src};
            data_in.zero_test        = 1'b1;
            data_in.flags.half_carry = 1'b0;
            data_in.flags.carry      = in_data.daa_carry;
         end
         ebalu_pkg::FN_CPL: begin
            data_in.result           = {8'h00, ~a};
            data_in.flags.subtract   = 1'b1;
            data_in.flags.half_carry = 1'b1;
         end
         ebalu_pkg::FN_SCF: begin
            data_in.flags.subtract   = 1'b0;
            data_in.flags.half_carry = 1'b0;
            data_in.flags.carry      = 1'b1;
         end
         ebalu_pkg::FN_CCF: begin
            data_in.flags.subtract   = 1'b0;
            data_in.flags.half_carry = 1'b0;
            data_in.flags.carry      = !cf;
         end
         ebalu_pkg::FN_RLC: begin
            data_in.zero_src = {a[6:0], a[7]};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::FN_RRC: begin
            data_in.zero_src = {a[0], a[7:1]};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::FN_RL: begin
            data_in.zero_src = {a[6:0], cf};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::FN_RR: begin
            data_in.zero_src = {cf, a[7:1]};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::FN_SLA: begin
            data_in.zero_src = {a[6:0], 1'b0};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::FN_SRA: begin
            data_in.zero_src = {a[7], a[7:1]};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::FN_SWAP: begin
            data_in.zero_src = {a[3:0], a[7:4]};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, 1'b0};
         end
         ebalu_pkg::FN_SRL: begin
            data_in.zero_src = {1'b0, a[7:1]};
            data_in.flags    = '{1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::FN_BIT: begin
            data_in.flags.zero       = ((a & in_data.bit_mask) == 8'h00);
            data_in.flags.subtract   = 1'b0;
            data_in.flags.half_carry = 1'b1;
         end
         ebalu_pkg::FN_RES: begin
            data_in.result = {8'h00, a & ~in_data.bit_mask};
         end
         ebalu_pkg::FN_SET: begin
            data_in.result = {8'h00, a | in_data.bit_mask};
         end
         default: begin
            data_in.result = in_data.operand_a;
         end
      endcase
      // cb rotates and shifts share one result path
      if ((in_data.func == ebalu_pkg::FN_RLC) || (in_data.func == ebalu_pkg::FN_RRC) ||
          (in_data.func == ebalu_pkg::FN_RL) || (in_data.func == ebalu_pkg::FN_RR) ||
          (in_data.func == ebalu_pkg::FN_SLA) || (in_data.func == ebalu_pkg::FN_SRA) ||
          (in_data.func == ebalu_pkg::FN_SWAP) || (in_data.func == ebalu_pkg::FN_SRL)) begin
         data_in.result    = {8'h00, data_in.zero_src};
         data_in.zero_test = 1'b1;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/ebalu_flags.sv
// third pipeline stage: zero detect, flag merge and output register
// depends on ebalu_pkg

module ebalu_flags (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ebalu_pkg::exe_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ebalu_pkg::rsp_type out_data
);

   logic               valid_ff;
   ebalu_pkg::rsp_type data_ff;
   ebalu_pkg::rsp_type data_in;

   always_comb begin
      data_in.result = in_data.result;
      data_in.flags  = in_data.flags;
      if (in_data.zero_test) begin
         data_in.flags.zero = (in_data.zero_src == 8'h00);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/eight_bit_cpu_alu_with_flags.sv
// arithmetic and flag unit of an 8-bit handheld-console cpu, three-stage pipeline.
// one transfer is taken on req_chan in every clock while the pipe is not
// stalled, and its result and the four new flags (zero, subtract, half-carry,
// carry) leave on rsp_chan after the three register stages (decode, execute,
// flag merge / output register). a stage holds its item while the one after it
// is full and stalled, so back pressure on rsp_chan stops the pipe without
// losing or repeating a transfer. 8-bit results come back zero-extended, cp and
// bit return operand_a, and unknown operation codes return operand_a with flags
// unchanged. depends on ebalu_pkg, ebalu_if and the three stage modules

module eight_bit_cpu_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   ebalu_req_if.sink   req_chan,
   ebalu_rsp_if.source rsp_chan
);

   // request packed into the pipeline payload
   ebalu_pkg::req_type req_data;

   // stage boundaries
   logic               dec_valid;
   logic               dec_ready;
   ebalu_pkg::dec_type dec_data;
   logic               exe_valid;
   logic               exe_ready;
   ebalu_pkg::exe_type exe_data;
   ebalu_pkg::rsp_type rsp_data;

   always_comb begin
      req_data.func             = ebalu_pkg::func_type'(req_chan.func);
      req_data.operand_a        = req_chan.operand_a;
      req_data.operand_b        = req_chan.operand_b;
      req_data.bit_index        = req_chan.bit_index;
      req_data.flags.zero       = req_chan.zero_in;
      req_data.flags.subtract   = req_chan.subtract_in;
      req_data.flags.half_carry = req_chan.half_carry_in;
      req_data.flags.carry      = req_chan.carry_in;
   end

   // stage 1: carry select, sign extension, bit mask, daa correction
   ebalu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // stage 2: adders, logic ops, rotates and shifts
   ebalu_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_ready (exe_ready),
      .out_data  (exe_data)
   );

   // stage 3: zero detect and output register
   ebalu_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exe_valid),
      .in_ready  (exe_ready),
      .in_data   (exe_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.result         = rsp_data.result;
   assign rsp_chan.zero_out       = rsp_data.flags.zero;
   assign rsp_chan.subtract_out   = rsp_data.flags.subtract;
   assign rsp_chan.half_carry_out = rsp_data.flags.half_carry;
   assign rsp_chan.carry_out      = rsp_data.flags.carry;

   // an accepted request always lands in the decode stage
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> dec_valid)
      else $error("accepted request missing from decode stage");

   // a full pipe with a stalled output refuses new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready && exe_valid && dec_valid |-> !req_chan.ready)
      else $error("request taken while pipeline is full and stalled");

   // nothing leaves in the cycle after reset
   assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule
